// File: src/assert_macros.svh
// Assertion macros for the checker file of the allocation bitmap.
// Needs nothing else; a file that asserts includes this header by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property, switched off while reset is asserted.
`define ABFF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition in a cycle implies a consequence in the following cycle.
`define ABFF_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// File: src/abff_pkg.sv
// Package for the allocation bitmap: field widths, command codes, sequencer states
// and the result structure of the per-word unit. Depends on nothing.
package abff_pkg;

  // Fixed field widths of the command and result words.
  localparam int IDX_W  = 10;
  localparam int CMD_W  = 4;
  localparam int CNT_W  = 11;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Value of the bit count register after reset.
  localparam logic [CNT_W-1:0] BITS_IN_USE_RST = 11'd1024;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_SET        = 4'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd1;
  localparam logic [CMD_W-1:0] CMD_TEST       = 4'd2;
  localparam logic [CMD_W-1:0] CMD_SET_ALL    = 4'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL  = 4'd4;
  localparam logic [CMD_W-1:0] CMD_INVERT     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_FIND_SET   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_FIND_CLEAR = 4'd7;
  localparam logic [CMD_W-1:0] CMD_ALL_CLEAR  = 4'd8;
  localparam logic [CMD_W-1:0] CMD_ALL_SET    = 4'd9;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  // What the per-word unit reports about one word.
  typedef struct packed {
    logic             any_match;
    logic [IDX_W-1:0] match_idx;
    logic             test_bit;
    logic             query_miss;
  } word_res_t;

endpackage

// File: src/abff_if.sv
// Valid/ready channel interfaces for the command word and the result word.
// Depends on abff_pkg for the field widths.
interface abff_in_if;
  logic                        valid;
  logic                        ready;
  logic [abff_pkg::CMD_W-1:0]  command;
  logic [abff_pkg::IDX_W-1:0]  bit_index;

  modport source (output valid, output command, output bit_index, input ready);
  modport sink   (input valid, input command, input bit_index, output ready);
endinterface

interface abff_out_if;
  logic                        valid;
  logic                        ready;
  logic                        bit_value;
  logic                        found;
  logic [abff_pkg::IDX_W-1:0]  found_index;
  logic                        index_error;

  modport source (output valid, output bit_value, output found, output found_index,
                  output index_error, input ready);
  modport sink   (input valid, input bit_value, input found, input found_index,
                  input index_error, output ready);
endinterface

// File: src/abff_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module abff_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/abff_word_op.sv
// Per-word unit of the allocation bitmap: modifies one stored word and scans it
// for the find and query commands. Depends on abff_pkg.
module abff_word_op #(
  parameter int WORD_BITS = 64,
  parameter int CW        = 11
) (
  input  logic [abff_pkg::CMD_W-1:0] cmd,
  input  logic [abff_pkg::IDX_W-1:0] idx,
  input  logic [CW-1:0]              base,
  input  logic [CW-1:0]              n,
  input  logic [WORD_BITS-1:0]       rdata,
  output logic [WORD_BITS-1:0]       wdata,
  output abff_pkg::word_res_t        res
);

  localparam int PW = $clog2(WORD_BITS);

  logic [CW-1:0]        idx_ext;
  logic [CW-1:0]        lim;
  logic [CW-1:0]        off;
  logic [CW:0]          top_w;
  logic                 in_word;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] onehot;
  logic [WORD_BITS-1:0] cand;
  logic [PW-1:0]        pos;
  logic [CW-1:0]        sum;

  // Masks: bits of this word below the count, and the addressed bit.
  always_comb begin
    idx_ext = CW'(idx);
    lim     = n - base;
    top_w   = {1'b0, base} + (CW+1)'(WORD_BITS);
    in_word = (idx_ext >= base) && ({1'b0, idx_ext} < top_w);
    off     = idx_ext - base;
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j]   = lim > CW'(j);
      onehot[j] = in_word && (off == CW'(j));
    end
  end

  // Lowest candidate bit for the find commands.
  always_comb begin
    if (cmd == abff_pkg::CMD_FIND_SET) begin
      cand = rdata & mask;
    end else begin
      cand = ~rdata & mask;
    end
    pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pos = PW'(j);
      end
    end
    sum = base + CW'(pos);
  end

  // Scan results for this word.
  always_comb begin
    res.any_match = |cand;
    res.match_idx = sum[abff_pkg::IDX_W-1:0];
    res.test_bit  = |(rdata & onehot);
    if (cmd == abff_pkg::CMD_ALL_SET) begin
      res.query_miss = |(~rdata & mask);
    end else begin
      res.query_miss = |(rdata & mask);
    end
  end

  // Modified word to write back.
  always_comb begin
    case (cmd)
      abff_pkg::CMD_SET:       wdata = rdata | onehot;
      abff_pkg::CMD_CLEAR:     wdata = rdata & ~onehot;
      abff_pkg::CMD_SET_ALL:   wdata = rdata | mask;
      abff_pkg::CMD_CLEAR_ALL: wdata = rdata & ~mask;
      abff_pkg::CMD_INVERT:    wdata = rdata ^ mask;
      default:                 wdata = rdata;
    endcase
  end

endmodule

// File: src/allocation_bitmap_find_first_top.sv
// Allocation bitmap with find-first-set and find-first-clear, stored as NUM_WORDS =
// ceil(NUM_BITS/WORD_BITS) words in one RAM with a registered read. After reset the
// block runs a clearing pass over all NUM_WORDS words during which no command word is
// taken. Each command then walks the RAM one word per cycle, reading word k+1 while
// the modified word k is written back: a command that touches the whole map walks
// the words up to n, the bit count (capped at NUM_BITS); a set, clear or test stops
// at the word that holds the bit; an unused code or out-of-range index walks none.
// One command is in work at a time; the next is taken while a finished result word
// still waits at the output register. Depends on abff_pkg, abff_if, abff_ram and
// abff_word_op.
module allocation_bitmap_find_first_top #(
  parameter int NUM_BITS  = 1024,
  parameter int WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  abff_in_if.sink                       in_ch,
  abff_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [abff_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [abff_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [abff_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int NUM_WORDS = (NUM_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BASE_W    = $clog2(NUM_WORDS * WORD_BITS + 1);
  localparam int CW        = (BASE_W > abff_pkg::CNT_W) ? BASE_W : abff_pkg::CNT_W;
  localparam logic [CW-1:0] NUM_BITS_C = CW'(NUM_BITS);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(NUM_WORDS - 1);

  abff_pkg::state_t state_r, state_nxt;

  logic [abff_pkg::CNT_W-1:0] bits_in_use_r;
  logic [abff_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [abff_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [AW-1:0]              addr_r, addr_nxt;
  logic [AW-1:0]              addr_d_r, addr_d_nxt;
  logic [CW-1:0]              base_r, base_nxt;
  logic [CW-1:0]              base_d_r, base_d_nxt;
  logic                       rv_r, rv_nxt;
  logic                       stop_r, stop_nxt;
  logic                       value_r, value_nxt;
  logic                       found_r, found_nxt;
  logic [abff_pkg::IDX_W-1:0] fidx_r, fidx_nxt;
  logic                       err_r, err_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_bit_value_r, out_bit_value_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [abff_pkg::IDX_W-1:0] out_found_index_r, out_found_index_nxt;
  logic                       out_index_error_r, out_index_error_nxt;

  logic [CW-1:0]              n_eff;
  logic                       more;
  logic                       is_bitop;
  logic                       in_ready;
  logic                       issue;
  logic                       clear_we;
  logic                       load_out;
  logic                       out_free;
  logic                       accept;
  logic                       cfg_wr;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [WORD_BITS-1:0]       ram_wdata;
  logic [WORD_BITS-1:0]       ram_rdata;
  logic [WORD_BITS-1:0]       op_wdata;
  abff_pkg::word_res_t        op_res;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = abff_pkg::CFG_DW'(bits_in_use_r);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_in_use_r <= abff_pkg::BITS_IN_USE_RST;
    end else if (cfg_wr) begin
      bits_in_use_r <= cfg_pwdata[abff_pkg::CNT_W-1:0];
    end
  end

  // Effective bit count and walk control.
  always_comb begin
    if (CW'(bits_in_use_r) > NUM_BITS_C) begin
      n_eff = NUM_BITS_C;
    end else begin
      n_eff = CW'(bits_in_use_r);
    end
    more     = (base_r < n_eff) && !stop_r;
    is_bitop = cmd_r inside {abff_pkg::CMD_SET, abff_pkg::CMD_CLEAR, abff_pkg::CMD_TEST};
    out_free = !out_valid_r || out_ch.ready;
    accept   = in_ch.valid && in_ready;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      abff_pkg::ST_CLEAR: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = abff_pkg::ST_IDLE;
        end
      end
      abff_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = abff_pkg::ST_WALK;
        end
      end
      abff_pkg::ST_WALK: begin
        if (!more) begin
          state_nxt = abff_pkg::ST_FINISH;
        end
      end
      abff_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = abff_pkg::ST_IDLE;
        end
      end
      default: state_nxt = abff_pkg::ST_IDLE;
    endcase
  end

  // State-decoded controls.
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    clear_we = 1'b0;
    load_out = 1'b0;
    case (state_r)
      abff_pkg::ST_CLEAR:  clear_we = 1'b1;
      abff_pkg::ST_IDLE:   in_ready = 1'b1;
      abff_pkg::ST_WALK:   issue    = more;
      abff_pkg::ST_FINISH: load_out = out_free;
      default: ;
    endcase
  end

  assign in_ch.ready = in_ready;

  // Bitmap storage: word read at the walk address, modified word written one behind.
  assign ram_we    = clear_we || (rv_r && (cmd_r inside {abff_pkg::CMD_SET,
                     abff_pkg::CMD_CLEAR, abff_pkg::CMD_SET_ALL,
                     abff_pkg::CMD_CLEAR_ALL, abff_pkg::CMD_INVERT}));
  assign ram_waddr = clear_we ? addr_r : addr_d_r;
  assign ram_wdata = clear_we ? '0 : op_wdata;

  abff_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  abff_word_op #(
    .WORD_BITS (WORD_BITS),
    .CW        (CW)
  ) u_word_op (
    .cmd   (cmd_r),
    .idx   (idx_r),
    .base  (base_d_r),
    .n     (n_eff),
    .rdata (ram_rdata),
    .wdata (op_wdata),
    .res   (op_res)
  );

  // Walk counters, command latch and accumulated results.
  always_comb begin
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    addr_nxt   = addr_r;
    addr_d_nxt = addr_d_r;
    base_nxt   = base_r;
    base_d_nxt = base_d_r;
    rv_nxt     = issue;
    stop_nxt   = stop_r;
    value_nxt  = value_r;
    found_nxt  = found_r;
    fidx_nxt   = fidx_r;
    err_nxt    = err_r;

    if (clear_we) begin
      addr_nxt = (addr_r == LAST_ADDR) ? '0 : addr_r + AW'(1);
    end

    if (accept) begin
      cmd_nxt   = in_ch.command;
      idx_nxt   = in_ch.bit_index;
      addr_nxt  = '0;
      base_nxt  = '0;
      value_nxt = (in_ch.command == abff_pkg::CMD_ALL_CLEAR) ||
                  (in_ch.command == abff_pkg::CMD_ALL_SET);
      found_nxt = 1'b0;
      fidx_nxt  = '0;
      err_nxt   = (in_ch.command inside {abff_pkg::CMD_SET, abff_pkg::CMD_CLEAR,
                   abff_pkg::CMD_TEST}) && (CW'(in_ch.bit_index) >= n_eff);
      // Unused codes and out-of-range indices skip the walk altogether.
      stop_nxt  = err_nxt || (in_ch.command > abff_pkg::CMD_ALL_SET);
    end

    // Issue a read and step to the next word; a single-bit command stops at its word.
    if (issue) begin
      addr_nxt   = addr_r + AW'(1);
      base_nxt   = base_r + CW'(WORD_BITS);
      addr_d_nxt = addr_r;
      base_d_nxt = base_r;
      if (is_bitop && (({1'b0, base_r} + (CW+1)'(WORD_BITS)) > (CW+1)'(idx_r))) begin
        stop_nxt = 1'b1;
      end
    end

    // Fold in the scan results of the word that has just been read.
    if (rv_r) begin
      case (cmd_r)
        abff_pkg::CMD_TEST: value_nxt = value_r | op_res.test_bit;
        abff_pkg::CMD_ALL_CLEAR,
        abff_pkg::CMD_ALL_SET: begin
          if (op_res.query_miss) begin
            value_nxt = 1'b0;
          end
        end
        abff_pkg::CMD_FIND_SET,
        abff_pkg::CMD_FIND_CLEAR: begin
          if (op_res.any_match && !found_r) begin
            found_nxt = 1'b1;
            fidx_nxt  = op_res.match_idx;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: holds a finished result word until it is taken.
  always_comb begin
    out_valid_nxt       = out_valid_r;
    out_bit_value_nxt   = out_bit_value_r;
    out_found_nxt       = out_found_r;
    out_found_index_nxt = out_found_index_r;
    out_index_error_nxt = out_index_error_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt       = 1'b1;
      out_bit_value_nxt   = value_r;
      out_found_nxt       = found_r;
      out_found_index_nxt = fidx_r;
      out_index_error_nxt = err_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.bit_value   = out_bit_value_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.found_index = out_found_index_r;
  assign out_ch.index_error = out_index_error_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= abff_pkg::ST_CLEAR;
      addr_r      <= '0;
      base_r      <= '0;
      rv_r        <= 1'b0;
      stop_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      base_r      <= base_nxt;
      rv_r        <= rv_nxt;
      stop_r      <= stop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r             <= cmd_nxt;
    idx_r             <= idx_nxt;
    addr_d_r          <= addr_d_nxt;
    base_d_r          <= base_d_nxt;
    value_r           <= value_nxt;
    found_r           <= found_nxt;
    fidx_r            <= fidx_nxt;
    err_r             <= err_nxt;
    out_bit_value_r   <= out_bit_value_nxt;
    out_found_r       <= out_found_nxt;
    out_found_index_r <= out_found_index_nxt;
    out_index_error_r <= out_index_error_nxt;
  end

endmodule

// File: src/abff_checker.sv
// Port-level checker for the allocation bitmap, bound to the top level below.
// Depends on assert_macros.svh and abff_pkg.
`include "assert_macros.svh"

module abff_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_bit_value,
  input logic                       out_found,
  input logic [abff_pkg::IDX_W-1:0] out_found_index,
  input logic                       out_index_error
);

  // A result word that is not taken stays offered.
  `ABFF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")

  // Only one command is in work: the block is busy in the cycle after it takes a word.
  `ABFF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "command word taken while busy")

  // A found bit comes only from a find, which neither tests a bit nor flags an error.
  `ABFF_ASSERT(a_found_exclusive, clk, rst_n, out_valid && out_found |-> !out_bit_value && !out_index_error, "found together with bit value or error")

  // Without a find hit the reported index is zero.
  `ABFF_ASSERT(a_index_zero, clk, rst_n, out_valid && !out_found |-> out_found_index == '0, "found index set without a hit")

endmodule

bind allocation_bitmap_find_first_top abff_checker u_abff_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_bit_value   (out_ch.bit_value),
  .out_found       (out_ch.found),
  .out_found_index (out_ch.found_index),
  .out_index_error (out_ch.index_error)
);

// File: test/allocation_bitmap_find_first_top_tb.sv
// Self-checking testbench for the allocation bitmap top level: drives command words
// and register writes, and checks every result word against a behavioural predictor.
// Depends on abff_pkg, abff_if and the RTL of allocation_bitmap_find_first_top.
module allocation_bitmap_find_first_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_BITS   = 1024;
  localparam int MAP_WORD   = 64;
  localparam int DRAIN_WAIT = 40;
  localparam logic [abff_pkg::CFG_AW-1:0] ADDR_BITS_IN_USE = '0;
  localparam logic [abff_pkg::CMD_W-1:0]  CMD_UNUSED_LO    = abff_pkg::CMD_ALL_SET + 1'b1;
  localparam logic [abff_pkg::CMD_W-1:0]  CMD_UNUSED_HI    = '1;

  // One result word as it leaves the block.
  typedef struct packed {
    logic                       bit_value;
    logic                       found;
    logic [abff_pkg::IDX_W-1:0] found_index;
    logic                       index_error;
  } result_t;

  // Shadow copy of the bitmap, the bit count and the results still owed.
  class bitmap_scoreboard;
    bit [MAP_BITS-1:0]          shadow;
    logic [abff_pkg::CNT_W-1:0] count;
    result_t                    owed_q[$];
    int unsigned                mismatches;

    function new();
      shadow     = '0;
      count      = abff_pkg::BITS_IN_USE_RST;
      mismatches = 0;
    endfunction

    function void set_count(logic [abff_pkg::CNT_W-1:0] value);
      count = value;
    endfunction

    function int unsigned live_bits();
      return (count > MAP_BITS) ? MAP_BITS : count;
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Apply one accepted command to the shadow map and queue the result it owes.
    function void note_command(logic [abff_pkg::CMD_W-1:0] cmd,
                               logic [abff_pkg::IDX_W-1:0] idx);
      int unsigned n;
      int unsigned i;
      bit          want;
      result_t     r;
      n = live_bits();
      r = '0;
      case (cmd)
        abff_pkg::CMD_SET, abff_pkg::CMD_CLEAR, abff_pkg::CMD_TEST: begin
          if (idx >= n) begin
            r.index_error = 1'b1;
          end else if (cmd == abff_pkg::CMD_SET) begin
            shadow[idx] = 1'b1;
          end else if (cmd == abff_pkg::CMD_CLEAR) begin
            shadow[idx] = 1'b0;
          end else begin
            r.bit_value = shadow[idx];
          end
        end
        abff_pkg::CMD_SET_ALL, abff_pkg::CMD_CLEAR_ALL: begin
          for (i = 0; i < n; i++) shadow[i] = (cmd == abff_pkg::CMD_SET_ALL);
        end
        abff_pkg::CMD_INVERT: begin
          for (i = 0; i < n; i++) shadow[i] = ~shadow[i];
        end
        abff_pkg::CMD_FIND_SET, abff_pkg::CMD_FIND_CLEAR: begin
          want = (cmd == abff_pkg::CMD_FIND_SET);
          for (i = 0; i < n && !r.found; i++) begin
            if (shadow[i] == want) begin
              r.found       = 1'b1;
              r.found_index = i[abff_pkg::IDX_W-1:0];
            end
          end
        end
        abff_pkg::CMD_ALL_CLEAR, abff_pkg::CMD_ALL_SET: begin
          want = (cmd == abff_pkg::CMD_ALL_SET);
          r.bit_value = 1'b1;
          for (i = 0; i < n && r.bit_value; i++) begin
            if (shadow[i] != want) r.bit_value = 1'b0;
          end
        end
        default: ;
      endcase
      owed_q.push_back(r);
    endfunction

    // Compare one accepted result word with the oldest owed result.
    task check_result(result_t got);
      result_t exp;
      if (owed_q.size() == 0) begin
        report("result word arrived with nothing expected");
      end else begin
        exp = owed_q.pop_front();
        if (got.bit_value !== exp.bit_value)
          report($sformatf("bit_value got %b, expected %b", got.bit_value, exp.bit_value));
        if (got.found !== exp.found)
          report($sformatf("found got %b, expected %b", got.found, exp.found));
        if (got.found_index !== exp.found_index)
          report($sformatf("found_index got %0d, expected %0d",
                           got.found_index, exp.found_index));
        if (got.index_error !== exp.index_error)
          report($sformatf("index_error got %b, expected %b",
                           got.index_error, exp.index_error));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [abff_pkg::CFG_AW-1:0] cfg_paddr;
  logic [abff_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [abff_pkg::CFG_DW-1:0] cfg_prdata;
  logic                        cfg_pready;

  abff_in_if  in_ch ();
  abff_out_if out_ch ();

  bitmap_scoreboard board;
  int unsigned      burst_left;

  allocation_bitmap_find_first_top #(
    .NUM_BITS  (MAP_BITS),
    .WORD_BITS (MAP_WORD)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Register write: setup cycle, then access cycle until pready.
  task cfg_write(logic [abff_pkg::CFG_AW-1:0] addr, logic [abff_pkg::CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_BITS_IN_USE) board.set_count(data[abff_pkg::CNT_W-1:0]);
  endtask

  // Offer one command word; bursts of back-to-back words are split by random gaps.
  task send_command(logic [abff_pkg::CMD_W-1:0] cmd, logic [abff_pkg::IDX_W-1:0] idx);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.bit_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    board.note_command(cmd, idx);
    burst_left--;
  endtask

  // Stop offering words, then wait for every owed result and let the block settle.
  task wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Index mostly inside the live bits, sometimes anywhere in the field.
  function automatic logic [abff_pkg::IDX_W-1:0] pick_index();
    int unsigned n;
    n = board.live_bits();
    if (n != 0 && $urandom_range(0, 99) < 85) return abff_pkg::IDX_W'($urandom_range(0, n - 1));
    return abff_pkg::IDX_W'($urandom_range(0, MAP_BITS - 1));
  endfunction

  // Command mix weighted towards single-bit updates so that the finds see varied maps.
  function automatic logic [abff_pkg::CMD_W-1:0] pick_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return abff_pkg::CMD_SET;
    if (r < 40) return abff_pkg::CMD_CLEAR;
    if (r < 52) return abff_pkg::CMD_TEST;
    if (r < 56) return abff_pkg::CMD_SET_ALL;
    if (r < 60) return abff_pkg::CMD_CLEAR_ALL;
    if (r < 64) return abff_pkg::CMD_INVERT;
    if (r < 76) return abff_pkg::CMD_FIND_SET;
    if (r < 88) return abff_pkg::CMD_FIND_CLEAR;
    if (r < 92) return abff_pkg::CMD_ALL_CLEAR;
    if (r < 96) return abff_pkg::CMD_ALL_SET;
    return abff_pkg::CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
  endfunction

  // Result side: accept words on a stall pattern that changes mode now and then.
  initial begin : result_side
    int unsigned cyc;
    int unsigned mode;
    int unsigned hold;
    logic        rdy;
    cyc  = 0;
    mode = 0;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        board.check_result({out_ch.bit_value, out_ch.found, out_ch.found_index,
                            out_ch.index_error});
      if (cyc % 300 == 0) mode = $urandom_range(0, 3);
      cyc++;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = ($urandom_range(0, 7) != 0);
        default: begin
          if (hold != 0) begin
            hold--;
            rdy = 1'b0;
          end else begin
            rdy = 1'b1;
            if ($urandom_range(0, 15) == 0) hold = $urandom_range(1, 30);
          end
        end
      endcase
      out_ch.ready <= rdy;
    end
  end

  // Stimulus.
  initial begin : stimulus
    logic [abff_pkg::CNT_W-1:0] phase_count [9];
    int unsigned                p;
    int unsigned                k;
    board       = new();
    burst_left  = 0;
    rst_n       <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= abff_pkg::CMD_TEST;
    in_ch.bit_index <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset count: map edges, every command but clear, unused codes.
    send_command(abff_pkg::CMD_TEST, '0);
    send_command(abff_pkg::CMD_SET, '0);
    send_command(abff_pkg::CMD_SET, '1);
    send_command(abff_pkg::CMD_TEST, '1);
    send_command(abff_pkg::CMD_FIND_SET, '0);
    send_command(abff_pkg::CMD_FIND_CLEAR, '0);
    send_command(abff_pkg::CMD_ALL_CLEAR, '0);
    send_command(abff_pkg::CMD_ALL_SET, '0);
    send_command(abff_pkg::CMD_INVERT, '0);
    send_command(abff_pkg::CMD_FIND_SET, '0);
    send_command(abff_pkg::CMD_FIND_CLEAR, '0);
    send_command(abff_pkg::CMD_SET_ALL, '0);
    send_command(abff_pkg::CMD_ALL_SET, '0);
    send_command(abff_pkg::CMD_FIND_CLEAR, '0);
    send_command(abff_pkg::CMD_CLEAR_ALL, '0);
    send_command(abff_pkg::CMD_ALL_CLEAR, '0);
    send_command(abff_pkg::CMD_FIND_SET, '0);
    send_command(CMD_UNUSED_LO, '1);
    send_command(CMD_UNUSED_HI, '1);

    // A count of zero: every index is out of range and both queries hold.
    wait_idle();
    cfg_write(ADDR_BITS_IN_USE, '0);
    send_command(abff_pkg::CMD_SET, 10'd5);
    send_command(abff_pkg::CMD_TEST, '0);
    send_command(abff_pkg::CMD_FIND_SET, '0);
    send_command(abff_pkg::CMD_ALL_CLEAR, '0);
    send_command(abff_pkg::CMD_ALL_SET, '0);

    // Random words over several counts, including one above the map size.
    phase_count[0] = 11'd1;
    phase_count[1] = 11'd0;
    phase_count[2] = '1;
    phase_count[3] = 11'd64;
    phase_count[4] = 11'd65;
    phase_count[5] = 11'd63;
    phase_count[6] = 11'd1000;
    phase_count[7] = abff_pkg::CNT_W'($urandom_range(1, MAP_BITS));
    phase_count[8] = 11'd1024;
    for (p = 0; p < 9; p++) begin
      wait_idle();
      cfg_write(ADDR_BITS_IN_USE,
                {{(abff_pkg::CFG_DW-abff_pkg::CNT_W){1'b0}}, phase_count[p]});
      for (k = 0; k < 210; k++) send_command(pick_command(), pick_index());
    end

    wait_idle();
    if (board.outstanding() != 0) board.report("results still owed at the end");
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
